// ----- rtl/core/ksdr_pkg.sv -----
// shared types and constants for the key scan debounce and auto-repeat block
package ksdr_pkg;

  // number of key lines used out of each 8-bit sample
  localparam int KEY_COUNT = 8;
  localparam int SAMPLE_W  = 8;
  localparam int DELAY_W   = 16;
  localparam int CFG_IDX_W = 3;

  // keys above KEY_COUNT are ignored
  localparam logic [SAMPLE_W-1:0] KEY_MASK = (KEY_COUNT >= SAMPLE_W) ?
    {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << KEY_COUNT) - 1);

  // register reset values
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 16'd200;
  localparam logic [DELAY_W-1:0] NEXT_DELAY_RST  = 16'd20;
  localparam logic               CHORDS_RST      = 1'b0;
  localparam logic               REPEAT_RST      = 1'b1;
  localparam logic               ACCEL_RST       = 1'b1;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_REPEAT_DELAY = 3'd0,
    CFG_NEXT_REPEAT_DELAY  = 3'd1,
    CFG_ALLOW_CHORDS       = 3'd2,
    CFG_REPEAT_ENABLE      = 3'd3,
    CFG_ACCELERATE_REPEAT  = 3'd4
  } cfg_idx_t;

  // current configuration as seen by the scan logic
  typedef struct packed {
    logic [DELAY_W-1:0] first_repeat_delay;
    logic [DELAY_W-1:0] next_repeat_delay;
    logic               allow_chords;
    logic               repeat_enable;
    logic               accelerate_repeat;
  } cfg_t;

endpackage

// ----- rtl/core/ksdr_if.sv -----
// valid/ready channel interfaces for scan items and key code results
interface ksdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_sample;
  logic [7:0] second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink   (input valid, input first_sample, input second_sample, output ready);
endinterface

interface ksdr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

// ----- rtl/core/key_scan_debounce_repeat.sv -----
// top level of the key scan debounce and auto-repeat block
//
// Usage:
//   in_ch   carries one scan per item: two 8-bit key samples taken a short
//           time apart, a set bit meaning the key is pressed.
//   out_ch  carries exactly one key_code per scan; 0 means no key event.
//   cfg_*   writes a register at any edge with cfg_we high; write only when
//           no scan is in flight.
// Latency: the key code of a scan is valid on out_ch the cycle after the
//   scan is accepted.
// Throughput: one scan per cycle; the decision is a compare, a one-hot test
//   and a 16-bit increment and compare on the state registers.
// Stall: while out_ch is stalled the result register keeps its item and
//   in_ch.ready drops; a scan is still taken in the cycle the held item
//   leaves.
// Reset: rst_n is synchronous; the registers return to their defaults
//   (200, 20, chords off, repeat on, accelerate on), the stored pattern and
//   hold count clear and the hold limit loads 200.
module key_scan_debounce_repeat (
  input  logic                            clk,
  input  logic                            rst_n,
  ksdr_in_if.sink                         in_ch,
  ksdr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ksdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ksdr_pkg::DELAY_W-1:0]    cfg_wdata
);

  ksdr_pkg::cfg_t                cfg;
  logic                          can_load;
  logic                          accept;
  logic [ksdr_pkg::SAMPLE_W-1:0] code;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  ksdr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ksdr_scan_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .step          (accept),
    .first_sample  (in_ch.first_sample),
    .second_sample (in_ch.second_sample),
    .key_code      (code)
  );

  ksdr_result_reg u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .code_in   (code),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .key_code  (out_ch.key_code),
    .can_load  (can_load)
  );

endmodule

// ----- rtl/core/ksdr_cfg_regs.sv -----
// configuration registers written through the plain write port
module ksdr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ksdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ksdr_pkg::DELAY_W-1:0]     cfg_wdata,
  output ksdr_pkg::cfg_t                   cfg
);

  ksdr_pkg::cfg_t cfg_r;
  ksdr_pkg::cfg_t cfg_nxt;

  // decode the write, indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ksdr_pkg::CFG_FIRST_REPEAT_DELAY: cfg_nxt.first_repeat_delay = cfg_wdata;
        ksdr_pkg::CFG_NEXT_REPEAT_DELAY:  cfg_nxt.next_repeat_delay  = cfg_wdata;
        ksdr_pkg::CFG_ALLOW_CHORDS:       cfg_nxt.allow_chords       = cfg_wdata[0];
        ksdr_pkg::CFG_REPEAT_ENABLE:      cfg_nxt.repeat_enable      = cfg_wdata[0];
        ksdr_pkg::CFG_ACCELERATE_REPEAT:  cfg_nxt.accelerate_repeat  = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_repeat_delay <= ksdr_pkg::FIRST_DELAY_RST;
      cfg_r.next_repeat_delay  <= ksdr_pkg::NEXT_DELAY_RST;
      cfg_r.allow_chords       <= ksdr_pkg::CHORDS_RST;
      cfg_r.repeat_enable      <= ksdr_pkg::REPEAT_RST;
      cfg_r.accelerate_repeat  <= ksdr_pkg::ACCEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/ksdr_scan_core.sv -----
// debounce and auto-repeat state with the per-scan decision logic
module ksdr_scan_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ksdr_pkg::cfg_t                  cfg,
  input  logic                            step,
  input  logic [ksdr_pkg::SAMPLE_W-1:0]   first_sample,
  input  logic [ksdr_pkg::SAMPLE_W-1:0]   second_sample,
  output logic [ksdr_pkg::SAMPLE_W-1:0]   key_code
);

  logic [ksdr_pkg::SAMPLE_W-1:0] prev_keys_r, prev_keys_nxt;
  logic [ksdr_pkg::DELAY_W-1:0]  hold_count_r, hold_count_nxt;
  logic [ksdr_pkg::DELAY_W-1:0]  hold_limit_r, hold_limit_nxt;

  logic [ksdr_pkg::SAMPLE_W-1:0] samp_a;
  logic [ksdr_pkg::SAMPLE_W-1:0] samp_b;
  logic                          single_key;
  logic [ksdr_pkg::DELAY_W-1:0]  count_inc;

  assign samp_a     = first_sample & ksdr_pkg::KEY_MASK;
  assign samp_b     = second_sample & ksdr_pkg::KEY_MASK;
  // exactly one key down: nonzero and a power of two
  assign single_key = (samp_a != '0) &&
                      ((samp_a & (samp_a - ksdr_pkg::SAMPLE_W'(1))) == '0);
  assign count_inc  = hold_count_r + ksdr_pkg::DELAY_W'(1);

  // per-scan decision: bounce, release, new pattern, held pattern
  always_comb begin
    prev_keys_nxt  = prev_keys_r;
    hold_count_nxt = hold_count_r;
    hold_limit_nxt = hold_limit_r;
    key_code       = '0;
    if (samp_a != samp_b) begin
      hold_count_nxt = '0;
    end else if (samp_a == '0) begin
      prev_keys_nxt  = '0;
      hold_count_nxt = '0;
      hold_limit_nxt = cfg.first_repeat_delay;
    end else if (prev_keys_r != samp_a) begin
      hold_count_nxt = '0;
      prev_keys_nxt  = samp_a;
      if (cfg.allow_chords || single_key) begin
        key_code = samp_a;
      end
    end else if (!cfg.allow_chords && !single_key) begin
      hold_count_nxt = '0;
    end else if (!cfg.repeat_enable) begin
      hold_count_nxt = '0;
    end else begin
      hold_count_nxt = count_inc;
      if (count_inc > hold_limit_r) begin
        hold_count_nxt = '0;
        key_code       = samp_a;
        // with accelerate on, switch to the short delay after the first repeat
        if (cfg.accelerate_repeat && (hold_limit_r == cfg.first_repeat_delay)) begin
          hold_limit_nxt = cfg.next_repeat_delay;
        end
      end
    end
  end

  // state advances only on an accepted scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r  <= '0;
      hold_count_r <= '0;
      hold_limit_r <= ksdr_pkg::FIRST_DELAY_RST;
    end else if (step) begin
      prev_keys_r  <= prev_keys_nxt;
      hold_count_r <= hold_count_nxt;
      hold_limit_r <= hold_limit_nxt;
    end
  end

endmodule

// ----- rtl/core/ksdr_result_reg.sv -----
// result register holding one key code item until the receiver takes it
module ksdr_result_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic [ksdr_pkg::SAMPLE_W-1:0]   code_in,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ksdr_pkg::SAMPLE_W-1:0]   key_code,
  output logic                            can_load
);

  logic                          valid_r, valid_nxt;
  logic [ksdr_pkg::SAMPLE_W-1:0] code_r;

  // free when empty or when the held item leaves this cycle
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= code_in;
    end
  end

  assign out_valid = valid_r;
  assign key_code  = code_r;

endmodule
